@@ hw/rtl/isbe_pkg.sv @@
// Package for the integer stack bytecode executor.
// Holds opcode constants, the instruction class decode and the ALU result type.
// No dependencies.
package isbe_pkg;

    localparam logic [7:0] OP_ICONST_M1 = 8'h02;
    localparam logic [7:0] OP_ICONST_5  = 8'h08;
    localparam logic [7:0] OP_BIPUSH    = 8'h10;
    localparam logic [7:0] OP_ILOAD_0   = 8'h1a;
    localparam logic [7:0] OP_ILOAD_3   = 8'h1d;
    localparam logic [7:0] OP_ISTORE_0  = 8'h3b;
    localparam logic [7:0] OP_ISTORE_3  = 8'h3e;
    localparam logic [7:0] OP_IADD      = 8'h60;
    localparam logic [7:0] OP_ISUB      = 8'h64;
    localparam logic [7:0] OP_IMUL      = 8'h68;
    localparam logic [7:0] OP_IINC      = 8'h84;
    localparam logic [7:0] OP_IF_ICMPLT = 8'ha1;
    localparam logic [7:0] OP_IRETURN   = 8'hac;

    localparam logic [31:0] CONST_BIAS = 32'd3;

    typedef enum logic [3:0] {
        CLS_NOP,
        CLS_CONST,
        CLS_BIPUSH,
        CLS_LOAD,
        CLS_STORE,
        CLS_ARITH,
        CLS_IINC,
        CLS_CMPLT,
        CLS_RET
    } op_class_t;

    typedef struct packed {
        logic [31:0] value;
        logic        cmp_less;
    } alu_res_t;

    function automatic op_class_t decode_op(logic [7:0] op);
        op_class_t cls;
        unique case (op) inside
            [OP_ICONST_M1:OP_ICONST_5]:    cls = CLS_CONST;
            OP_BIPUSH:                     cls = CLS_BIPUSH;
            [OP_ILOAD_0:OP_ILOAD_3]:       cls = CLS_LOAD;
            [OP_ISTORE_0:OP_ISTORE_3]:     cls = CLS_STORE;
            OP_IADD, OP_ISUB, OP_IMUL:     cls = CLS_ARITH;
            OP_IINC:                       cls = CLS_IINC;
            OP_IF_ICMPLT:                  cls = CLS_CMPLT;
            OP_IRETURN:                    cls = CLS_RET;
            default:                       cls = CLS_NOP;
        endcase
        return cls;
    endfunction

endpackage

@@ hw/rtl/isbe_stack_ram.sv @@
// Operand stack memory: two registered read ports, one write port.
// Depends on nothing but the clock; the controller sequences all accesses.
module isbe_stack_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          re,
    input  logic [AW-1:0] ra_addr,
    input  logic [AW-1:0] rb_addr,
    output logic [31:0]   ra_data,
    output logic [31:0]   rb_data,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] ra_data_reg;
    logic [31:0] rb_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            ra_data_reg <= mem[ra_addr];
            rb_data_reg <= mem[rb_addr];
        end
    end

    assign ra_data = ra_data_reg;
    assign rb_data = rb_data_reg;

endmodule

@@ hw/rtl/isbe_local_ram.sv @@
// Local variable memory: one registered read port, one write port.
// Depends on nothing but the clock; the controller sequences all accesses.
module isbe_local_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/isbe_alu.sv @@
// Execute datapath: pushes (constant, byte, local), add, sub, mul, iinc, compare.
// Depends on isbe_pkg for opcodes, the class type and the result struct.
module isbe_alu (
    input  isbe_pkg::op_class_t cls,
    input  logic [7:0]          func,
    input  logic [7:0]          arg,
    input  logic signed [7:0]   arg2,
    input  logic [31:0]         top,
    input  logic [31:0]         below,
    input  logic [31:0]         local_q,
    output isbe_pkg::alu_res_t  res
);
    import isbe_pkg::*;

    logic [31:0] prod;

    assign prod = 32'(below * top);

    always_comb
    begin
        res.value    = '0;
        res.cmp_less = 1'b0;
        case (cls)
            CLS_CONST:  res.value = 32'(func) - CONST_BIAS;
            CLS_BIPUSH: res.value = {{24{arg[7]}}, arg};
            CLS_LOAD:   res.value = local_q;
            CLS_STORE,
            CLS_RET:    res.value = top;
            CLS_ARITH:
            begin
                case (func)
                    OP_IADD: res.value = below + top;
                    OP_ISUB: res.value = below - top;
                    default: res.value = prod;
                endcase
            end
            CLS_IINC:   res.value = local_q + 32'(arg2);
            CLS_CMPLT:  res.cmp_less = $signed(below) < $signed(top);
            default:    res.value = '0;
        endcase
    end

endmodule

@@ hw/rtl/int_stack_bytecode_executor.sv @@
// Top level of the integer stack bytecode executor: sequencer, stack pointer, result register.
// Depends on isbe_pkg, isbe_stack_ram, isbe_local_ram and isbe_alu.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | in_valid / in_stall  | func, arg, arg2
//   output   | out_valid / out_stall| ret_valid, ret_value, cmp_less, halted
//
// For each item the accept edge launches the stack and locals reads; the ST_EXEC state then
// executes and writes back through the single write port of each memory.
// After reset a clearing pass over max(STACK_DEPTH, LOCALS_DEPTH) addresses zeroes both
// memories; in_stall stays high during it.
// A stalled result holds the execute step; the next item may be accepted while it waits.
module int_stack_bytecode_executor #(
    parameter int STACK_DEPTH  = 256,
    parameter int LOCALS_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         func,
    input  logic [7:0]         arg,
    input  logic signed [7:0]  arg2,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ret_valid,
    output logic signed [31:0] ret_value,
    output logic               cmp_less,
    output logic               halted
);
    import isbe_pkg::*;

    localparam int SW        = $clog2(STACK_DEPTH);
    localparam int LW        = $clog2(LOCALS_DEPTH);
    localparam int CLR_DEPTH = (STACK_DEPTH > LOCALS_DEPTH) ? STACK_DEPTH : LOCALS_DEPTH;
    localparam int CW        = $clog2(CLR_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [SW-1:0]   sp_reg, sp_next;
    logic            halt_reg, halt_next;
    logic            out_valid_reg, out_valid_next;

    op_class_t       cls_reg;
    logic [7:0]      func_reg;
    logic [7:0]      arg_reg;
    logic signed [7:0] arg2_reg;
    logic [LW-1:0]   laddr_reg;

    logic            ret_valid_reg;
    logic [31:0]     ret_value_reg;
    logic            cmp_less_reg;
    logic            halted_reg;

    logic [LW-1:0]   mod_tab [256];
    logic            in_acc;
    logic            exec_go;
    logic            clr_last;
    logic            clr_stk;
    logic            clr_loc;
    op_class_t       acc_cls;
    logic [1:0]      ld_idx;
    logic [1:0]      st_idx;
    logic [LW-1:0]   laddr_acc;
    logic [SW-1:0]   sp_inc;
    logic [SW-1:0]   sp_dec1;
    logic [SW-1:0]   sp_dec2;

    logic            stk_we;
    logic [SW-1:0]   stk_waddr;
    logic [31:0]     stk_wdata;
    logic [31:0]     stk_top;
    logic [31:0]     stk_below;
    logic            loc_we;
    logic [LW-1:0]   loc_waddr;
    logic [31:0]     loc_wdata;
    logic [31:0]     loc_q;
    alu_res_t        alu_res;

    for (genvar gi = 0; gi < 256; gi++)
    begin : g_mod
        assign mod_tab[gi] = LW'(gi % LOCALS_DEPTH);
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && (state_reg == ST_IDLE);
    assign exec_go  = (state_reg == ST_EXEC) && !(out_valid_reg && out_stall);
    assign clr_last = (clr_cnt_reg == CW'(CLR_DEPTH - 1));
    assign clr_stk  = {1'b0, clr_cnt_reg} < (CW + 1)'(STACK_DEPTH);
    assign clr_loc  = {1'b0, clr_cnt_reg} < (CW + 1)'(LOCALS_DEPTH);

    assign sp_inc  = (sp_reg == SW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec1 = (sp_reg == '0) ? SW'(STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign sp_dec2 = (sp_dec1 == '0) ? SW'(STACK_DEPTH - 1) : sp_dec1 - 1'b1;

    assign acc_cls = decode_op(func);
    assign ld_idx  = 2'(func - OP_ILOAD_0);
    assign st_idx  = 2'(func - OP_ISTORE_0);

    always_comb
    begin
        case (acc_cls)
            CLS_LOAD:  laddr_acc = LW'(ld_idx);
            CLS_STORE: laddr_acc = LW'(st_idx);
            default:   laddr_acc = mod_tab[arg];
        endcase
    end

    isbe_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (SW)
    ) u_stack (
        .clk     (clk),
        .re      (in_acc),
        .ra_addr (sp_dec1),
        .rb_addr (sp_dec2),
        .ra_data (stk_top),
        .rb_data (stk_below),
        .we      (stk_we),
        .waddr   (stk_waddr),
        .wdata   (stk_wdata)
    );

    isbe_local_ram #(
        .DEPTH (LOCALS_DEPTH),
        .AW    (LW)
    ) u_locals (
        .clk   (clk),
        .re    (in_acc),
        .raddr (laddr_acc),
        .rdata (loc_q),
        .we    (loc_we),
        .waddr (loc_waddr),
        .wdata (loc_wdata)
    );

    isbe_alu u_alu (
        .cls     (cls_reg),
        .func    (func_reg),
        .arg     (arg_reg),
        .arg2    (arg2_reg),
        .top     (stk_top),
        .below   (stk_below),
        .local_q (loc_q),
        .res     (alu_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        sp_next        = sp_reg;
        halt_next      = halt_reg;
        out_valid_next = out_valid_reg && out_stall;
        stk_we         = 1'b0;
        stk_waddr      = clr_cnt_reg[SW-1:0];
        stk_wdata      = '0;
        loc_we         = 1'b0;
        loc_waddr      = clr_cnt_reg[LW-1:0];
        loc_wdata      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                stk_we       = clr_stk;
                loc_we       = clr_loc;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    stk_wdata      = alu_res.value;
                    loc_waddr      = laddr_reg;
                    loc_wdata      = alu_res.value;
                    case (cls_reg)
                        CLS_CONST, CLS_BIPUSH, CLS_LOAD:
                        begin
                            stk_we    = 1'b1;
                            stk_waddr = sp_reg;
                            sp_next   = sp_inc;
                        end
                        CLS_ARITH:
                        begin
                            stk_we    = 1'b1;
                            stk_waddr = sp_dec2;
                            sp_next   = sp_dec1;
                        end
                        CLS_STORE:
                        begin
                            loc_we  = 1'b1;
                            sp_next = sp_dec1;
                        end
                        CLS_IINC:
                        begin
                            loc_we = 1'b1;
                        end
                        CLS_CMPLT:
                        begin
                            sp_next = sp_dec2;
                        end
                        CLS_RET:
                        begin
                            sp_next   = sp_dec1;
                            halt_next = 1'b1;
                        end
                        default:
                        begin
                            sp_next = sp_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            sp_reg        <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            sp_reg        <= sp_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cls_reg   <= acc_cls;
            func_reg  <= func;
            arg_reg   <= arg;
            arg2_reg  <= arg2;
            laddr_reg <= laddr_acc;
        end
        if (exec_go)
        begin
            ret_valid_reg <= (cls_reg == CLS_RET);
            ret_value_reg <= (cls_reg == CLS_RET) ? alu_res.value : '0;
            cmp_less_reg  <= (cls_reg == CLS_CMPLT) && alu_res.cmp_less;
            halted_reg    <= halt_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign ret_valid = ret_valid_reg;
    assign ret_value = ret_value_reg;
    assign cmp_less  = cmp_less_reg;
    assign halted    = halted_reg;

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared after being set");

    a_ret_implies_halted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ret_valid) |-> halted)
        else $error("return item without halted flag");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_EXEC))
        else $error("accepted item did not reach execute");

    a_push_advances_sp: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && (cls_reg == CLS_CONST || cls_reg == CLS_BIPUSH || cls_reg == CLS_LOAD))
        |=> (sp_reg == $past(sp_inc)))
        else $error("push did not advance stack pointer");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for int_stack_bytecode_executor: a directed instruction table,
// then random programs under several idle and stall mixes, checked against an in-bench model.
// Depends on isbe_pkg and the executor RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import isbe_pkg::*;

    localparam int STACK_DEPTH    = 256;
    localparam int LOCALS_DEPTH   = 256;
    localparam int HOLD_CYCLES    = 64;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [7:0] OP_NOP       = 8'h00;
    localparam logic [7:0] OP_UNUSED_FF = 8'hff;
    localparam logic [7:0] OP_GOTO      = 8'ha7;
    localparam logic [7:0] OP_ICONST_2  = 8'h05;
    localparam logic [7:0] OP_ILOAD_1   = 8'h1b;

    typedef struct packed {
        logic        ret_valid;
        logic [31:0] ret_value;
        logic        cmp_less;
        logic        halted;
    } exec_result_t;

    typedef struct packed {
        logic [7:0]   func;
        logic [7:0]   arg;
        logic [7:0]   arg2;
        logic         typed;
        exec_result_t want;
    } directed_row_t;

    localparam exec_result_t RES_QUIET = '0;
    localparam exec_result_t RES_LESS  = {1'b0, 32'd0, 1'b1, 1'b0};

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         func;
    logic [7:0]         arg;
    logic signed [7:0]  arg2;
    logic               out_valid;
    logic               out_stall;
    logic               ret_valid;
    logic signed [31:0] ret_value;
    logic               cmp_less;
    logic               halted;

    logic [31:0] operand_mirror [STACK_DEPTH];
    logic [31:0] locals_mirror [LOCALS_DEPTH];
    int          sp_mirror;
    logic        halt_mirror;

    exec_result_t expected_results [$];

    int gap_pct       = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int returns_seen  = 0;
    int less_seen     = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;

    directed_row_t directed_program [24] = '{
        '{OP_NOP,       8'h00, 8'h00, 1'b1, RES_QUIET},
        '{OP_UNUSED_FF, 8'hff, 8'hff, 1'b1, RES_QUIET},
        '{OP_ICONST_M1, 8'h00, 8'h00, 1'b1, RES_QUIET},
        '{OP_ICONST_5,  8'h00, 8'h00, 1'b1, RES_QUIET},
        '{OP_IF_ICMPLT, 8'h00, 8'h00, 1'b1, RES_LESS},
        '{OP_BIPUSH,    8'h7f, 8'h00, 1'b1, RES_QUIET},
        '{OP_BIPUSH,    8'h80, 8'h00, 1'b1, RES_QUIET},
        '{OP_IF_ICMPLT, 8'h00, 8'h00, 1'b1, RES_QUIET},
        '{OP_BIPUSH,    8'h7f, 8'h00, 1'b1, RES_QUIET},
        '{OP_BIPUSH,    8'h7f, 8'h00, 1'b1, RES_QUIET},
        '{OP_IMUL,      8'h00, 8'h00, 1'b0, RES_QUIET},
        '{OP_ISTORE_0,  8'h00, 8'h00, 1'b0, RES_QUIET},
        '{OP_IINC,      8'h00, 8'h7f, 1'b0, RES_QUIET},
        '{OP_IINC,      8'hff, 8'h80, 1'b0, RES_QUIET},
        '{OP_ILOAD_0,   8'h00, 8'h00, 1'b0, RES_QUIET},
        '{OP_ILOAD_3,   8'h00, 8'h00, 1'b0, RES_QUIET},
        '{OP_ISUB,      8'h00, 8'h00, 1'b0, RES_QUIET},
        '{OP_ICONST_2,  8'h00, 8'h00, 1'b0, RES_QUIET},
        '{OP_IADD,      8'h00, 8'h00, 1'b0, RES_QUIET},
        '{OP_ISTORE_3,  8'h00, 8'h00, 1'b0, RES_QUIET},
        '{OP_GOTO,      8'h00, 8'h00, 1'b1, RES_QUIET},
        '{OP_IRETURN,   8'h00, 8'h00, 1'b0, RES_QUIET},
        '{OP_ILOAD_1,   8'h00, 8'h00, 1'b0, RES_QUIET},
        '{OP_IRETURN,   8'h00, 8'h00, 1'b0, RES_QUIET}
    };

    int_stack_bytecode_executor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .arg       (arg),
        .arg2      (arg2),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ret_valid (ret_valid),
        .ret_value (ret_value),
        .cmp_less  (cmp_less),
        .halted    (halted)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void push_operand(logic [31:0] value);
        operand_mirror[sp_mirror] = value;
        sp_mirror = (sp_mirror + 1) % STACK_DEPTH;
    endfunction

    function automatic logic [31:0] pop_operand();
        sp_mirror = (sp_mirror + STACK_DEPTH - 1) % STACK_DEPTH;
        return operand_mirror[sp_mirror];
    endfunction

    function automatic exec_result_t execute_bytecode(logic [7:0] op, logic [7:0] a,
                                                      logic [7:0] a2);
        exec_result_t r;
        logic [31:0]  top;
        logic [31:0]  below;
        int           idx;
        r = '0;
        if (op inside {[OP_ICONST_M1:OP_ICONST_5]})
            push_operand({24'd0, op} - CONST_BIAS);
        else if (op == OP_BIPUSH)
            push_operand({{24{a[7]}}, a});
        else if (op inside {[OP_ILOAD_0:OP_ILOAD_3]})
            push_operand(locals_mirror[op - OP_ILOAD_0]);
        else if (op inside {[OP_ISTORE_0:OP_ISTORE_3]})
            locals_mirror[op - OP_ISTORE_0] = pop_operand();
        else if (op inside {OP_IADD, OP_ISUB, OP_IMUL})
        begin
            top = pop_operand();
            below = pop_operand();
            case (op)
                OP_IADD: push_operand(below + top);
                OP_ISUB: push_operand(below - top);
                default: push_operand(below * top);
            endcase
        end
        else if (op == OP_IINC)
        begin
            idx = a % LOCALS_DEPTH;
            locals_mirror[idx] = locals_mirror[idx] + {{24{a2[7]}}, a2};
        end
        else if (op == OP_IF_ICMPLT)
        begin
            top = pop_operand();
            below = pop_operand();
            r.cmp_less = $signed(below) < $signed(top);
        end
        else if (op == OP_IRETURN)
        begin
            r.ret_value = pop_operand();
            r.ret_valid = 1'b1;
            halt_mirror = 1'b1;
        end
        r.halted = halt_mirror;
        return r;
    endfunction

    task automatic send_item(input logic [7:0] f, input logic [7:0] a, input logic [7:0] a2,
                             input logic typed, input exec_result_t typed_want);
        exec_result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        arg <= a;
        arg2 <= a2;
        do
            @(posedge clk);
        while (in_stall);
        predicted = execute_bytecode(f, a, a2);
        expected_results.push_back(typed ? typed_want : predicted);
        items_sent++;
    endtask

    task automatic pick_instruction(input bit push_only, output logic [7:0] f);
        int sel;
        sel = $urandom_range(0, 99);
        if (push_only)
            f = (sel < 50) ? OP_ICONST_M1 + 8'($urandom_range(0, 6)) : OP_BIPUSH;
        else if (sel < 20)
            f = OP_ICONST_M1 + 8'($urandom_range(0, 6));
        else if (sel < 32)
            f = OP_BIPUSH;
        else if (sel < 44)
            f = OP_ILOAD_0 + 8'($urandom_range(0, 3));
        else if (sel < 54)
            f = OP_ISTORE_0 + 8'($urandom_range(0, 3));
        else if (sel < 72)
        begin
            case ($urandom_range(0, 2))
                0: f = OP_IADD;
                1: f = OP_ISUB;
                default: f = OP_IMUL;
            endcase
        end
        else if (sel < 80)
            f = OP_IINC;
        else if (sel < 88)
            f = OP_IF_ICMPLT;
        else if (sel < 92)
            f = OP_IRETURN;
        else
            f = 8'($urandom());
    endtask

    task automatic run_phase(input int count, input int gap, input int stall,
                             input bit push_only);
        logic [7:0] f;
        gap_pct = gap;
        stall_pct = stall;
        repeat (count)
        begin
            pick_instruction(push_only, f);
            send_item(f, 8'($urandom()), 8'($urandom()), 1'b0, RES_QUIET);
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_failure(input string why, input exec_result_t want,
                                  input exec_result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t %s: expected ret=%0b val=%0d lt=%0b halt=%0b, got ret=%0b val=%0d lt=%0b halt=%0b",
                     $realtime, why, want.ret_valid, $signed(want.ret_value), want.cmp_less,
                     want.halted, got.ret_valid, $signed(got.ret_value), got.cmp_less,
                     got.halted);
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        exec_result_t got;
        exec_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {ret_valid, ret_value, cmp_less, halted};
            results_seen++;
            if (got.ret_valid)
                returns_seen++;
            if (got.cmp_less)
                less_seen++;
            if (expected_results.size() == 0)
                report_failure("unexpected result", RES_QUIET, got);
            else
            begin
                want = expected_results.pop_front();
                if (got.ret_valid !== want.ret_valid || got.ret_value !== want.ret_value ||
                    got.cmp_less !== want.cmp_less || got.halted !== want.halted)
                    report_failure("result mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0;
        arg = '0;
        arg2 = '0;
        for (int n = 0; n < STACK_DEPTH; n++)
            operand_mirror[n] = '0;
        for (int n = 0; n < LOCALS_DEPTH; n++)
            locals_mirror[n] = '0;
        sp_mirror = 0;
        halt_mirror = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_program[n])
            send_item(directed_program[n].func, directed_program[n].arg,
                      directed_program[n].arg2, directed_program[n].typed,
                      directed_program[n].want);

        run_phase(180, 0, 0, 1'b0);
        hold_requests++;
        run_phase(40, 0, 0, 1'b0);
        wait_for_results();
        run_phase(180, 80, 0, 1'b0);
        run_phase(180, 0, 80, 1'b0);
        run_phase(180, 8, 8, 1'b0);
        // overrun the stack so the pointer wraps, then pop back through old entries
        run_phase(300, 0, 0, 1'b1);
        run_phase(60, 0, 0, 1'b0);
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Executed %0d instructions, checked %0d results (%0d returns, %0d true compares)",
                 items_sent, results_seen, returns_seen, less_seen);
        $display("Mixes: free-running, sender gaps, output stalls, light both, hold-off, wrap");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
